/* hdl/jgcb_pkg.sv */
// Shared constants, types and the gear table generator for the chunk boundary block.
package jgcb_pkg;

  localparam int OFFSET_W           = 48;
  localparam int GEAR_ENTRIES       = 256;
  localparam int MAX_T              = 24;
  localparam int TARGET_MIN         = 3;
  localparam int MAX_EXTRA_LOG2     = 1;
  localparam int DEFAULT_SIZE_SHIFT = 2;
  localparam int SEED_LENGTH        = 64;

  localparam int BYTE_W    = 8;
  localparam int TGT_W     = 5;
  localparam int SWL_W     = 3;
  localparam int WIN_W     = 7;
  localparam int MASK_W    = 64;
  localparam int START_W   = 48;
  localparam int LEN_W     = 26;
  localparam int CD_W      = MAX_T;
  localparam int GEAR_AW   = $clog2(GEAR_ENTRIES);
  localparam int WCMP_W    = (CD_W > WIN_W) ? CD_W : WIN_W;
  localparam int CMP_A_W   = (OFFSET_W + 1 > MAX_T + 2) ? OFFSET_W + 1 : MAX_T + 2;
  localparam int CMP_W     = (CMP_A_W > LEN_W) ? CMP_A_W : LEN_W;

  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = REG_IDX_W + 3;
  localparam int PDATA_W   = 64;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_LOG2      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_WINDOW_LOG2 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHUNK_MASK       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_JUMP_MASK        = 3'd4;

  localparam logic [TGT_W-1:0]  TARGET_LOG2_RST      = 5'd13;
  localparam logic [SWL_W-1:0]  SIZE_WINDOW_LOG2_RST = 3'd2;
  localparam logic [WIN_W-1:0]  WINDOW_LEN_RST       = 7'd48;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_FILL   = 2'd1;
  localparam logic [1:0] PH_SEARCH = 2'd2;
  localparam logic [1:0] PH_JUMP   = 2'd3;

  // Phase entry points and limits derived from the configuration registers.
  typedef struct packed {
    logic [1:0]       first_phase;
    logic [CD_W-1:0]  first_cd;
    logic [1:0]       fill_phase;
    logic [CD_W-1:0]  fill_cd;
    logic [CD_W-1:0]  jump_cd;
    logic [CMP_W-1:0] max_m1;
  } chunk_plan_t;

  typedef struct packed {
    logic [MASK_W-1:0] cut_bits;
    logic [MASK_W-1:0] hop_bits;
    chunk_plan_t       plan;
  } cfg_t;

  typedef struct packed {
    logic               cut;
    logic [START_W-1:0] chunk_start;
    logic [LEN_W-1:0]   chunk_length;
  } res_t;

  typedef logic [3:0][31:0]  md5_state_t;
  typedef logic [15:0][31:0] md5_words_t;
  typedef logic [63:0] gear_rom_t [GEAR_ENTRIES];

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int MD5_S [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                4, 11, 16, 23, 6, 10, 15, 21};

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic md5_state_t md5_block(input md5_state_t h, input md5_words_t w);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] f;
    logic [31:0] t;
    int          g;
    md5_state_t  r;
    a = h[0];
    b = h[1];
    c = h[2];
    d = h[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d);
        g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c);
        g = (5 * i + 1) & 15;
      end else if (i < 48) begin
        f = b ^ c ^ d;
        g = (3 * i + 5) & 15;
      end else begin
        f = c ^ (b | ~d);
        g = (7 * i) & 15;
      end
      t = d;
      d = c;
      c = b;
      b = b + md5_rotl(a + f + MD5_K[i] + w[g], MD5_S[((i >> 4) << 2) | (i & 3)]);
      a = t;
    end
    r[0] = h[0] + a;
    r[1] = h[1] + b;
    r[2] = h[2] + c;
    r[3] = h[3] + d;
    return r;
  endfunction

  // Low eight digest bytes of a message made of SEED_LENGTH copies of the index byte.
  function automatic logic [63:0] gear_entry(input logic [7:0] idx);
    md5_state_t h;
    md5_words_t w;
    h[0] = 32'h67452301;
    h[1] = 32'hefcdab89;
    h[2] = 32'h98badcfe;
    h[3] = 32'h10325476;
    w = {16{{4{idx}}}};
    h = md5_block(h, w);
    w = '0;
    w[0] = 32'h80;
    w[14] = 32'(SEED_LENGTH * 8);
    h = md5_block(h, w);
    return {h[1], h[0]};
  endfunction

  function automatic gear_rom_t gear_build();
    gear_rom_t rom;
    for (int i = 0; i < GEAR_ENTRIES; i++) begin
      rom[i] = gear_entry(8'(i));
    end
    return rom;
  endfunction

endpackage

/* hdl/jgcb_gear_rom.sv */
// Synchronous gear table ROM with one registered read port.
module jgcb_gear_rom
  import jgcb_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  logic [GEAR_AW-1:0] addr,
  output logic [63:0]        rd_data
);

  localparam gear_rom_t GEAR_ROM = gear_build();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= GEAR_ROM[addr];
    end
  end

endmodule

/* hdl/jgcb_cfg.sv */
// APB-style configuration registers and the derived chunk plan.
module jgcb_cfg
  import jgcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg,
  output logic               cfg_wr
);

  logic [TGT_W-1:0]  target_r,   target_nxt;
  logic [SWL_W-1:0]  swl_r,      swl_nxt;
  logic [WIN_W-1:0]  win_len_r,  win_len_nxt;
  logic [MASK_W-1:0] cmask_r,    cmask_nxt;
  logic [MASK_W-1:0] jmask_r,    jmask_nxt;
  chunk_plan_t       plan_r,     plan_nxt;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  logic [TGT_W-1:0]     t_eff;
  logic [SWL_W-1:0]     s_eff;
  logic [CD_W-1:0]      min_size;
  logic [WCMP_W-1:0]    min_ext;
  logic [WCMP_W-1:0]    wl_ext;
  logic [WCMP_W-1:0]    win_eff;
  logic [CD_W-1:0]      win_cd;
  logic [CD_W-1:0]      skip_cd;
  logic [TGT_W:0]       max_shift;

  assign idx    = paddr[PADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_wr = wr_en && (idx <= REG_JUMP_MASK);

  always_comb begin
    target_nxt  = target_r;
    swl_nxt     = swl_r;
    win_len_nxt = win_len_r;
    cmask_nxt   = cmask_r;
    jmask_nxt   = jmask_r;
    if (!rst_n) begin
      target_nxt  = TARGET_LOG2_RST;
      swl_nxt     = SIZE_WINDOW_LOG2_RST;
      win_len_nxt = WINDOW_LEN_RST;
      cmask_nxt   = '0;
      jmask_nxt   = '0;
    end else if (wr_en) begin
      case (idx)
        REG_TARGET_LOG2:      target_nxt  = pwdata[TGT_W-1:0];
        REG_SIZE_WINDOW_LOG2: swl_nxt     = pwdata[SWL_W-1:0];
        REG_WINDOW_LEN:       win_len_nxt = pwdata[WIN_W-1:0];
        REG_CHUNK_MASK:       cmask_nxt   = pwdata[MASK_W-1:0];
        REG_JUMP_MASK:        jmask_nxt   = pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // The plan follows the values being written, so it is ready at the same edge.
  always_comb begin
    if (target_nxt < TGT_W'(TARGET_MIN)) begin
      t_eff = TGT_W'(TARGET_MIN);
    end else if (target_nxt > TGT_W'(MAX_T)) begin
      t_eff = TGT_W'(MAX_T);
    end else begin
      t_eff = target_nxt;
    end
    s_eff = (swl_nxt != '0) ? swl_nxt : SWL_W'(DEFAULT_SIZE_SHIFT);
    if (TGT_W'(s_eff) >= t_eff) begin
      min_size = CD_W'(1);
    end else begin
      min_size = CD_W'(1) << (t_eff - TGT_W'(s_eff));
    end
    min_ext = WCMP_W'(min_size);
    wl_ext  = WCMP_W'(win_len_nxt);
    win_eff = (min_ext < wl_ext) ? min_ext : wl_ext;
    win_cd  = CD_W'(win_eff);
    skip_cd = min_size - win_cd;
    max_shift = {1'b0, t_eff} + (TGT_W + 1)'(MAX_EXTRA_LOG2);

    plan_nxt.fill_phase = (win_cd != '0) ? PH_FILL : PH_SEARCH;
    plan_nxt.fill_cd    = win_cd;
    if (skip_cd != '0) begin
      plan_nxt.first_phase = PH_SKIP;
      plan_nxt.first_cd    = skip_cd;
    end else begin
      plan_nxt.first_phase = plan_nxt.fill_phase;
      plan_nxt.first_cd    = win_cd;
    end
    plan_nxt.jump_cd = CD_W'(1) << (t_eff - TGT_W'(1));
    plan_nxt.max_m1  = (CMP_W'(1) << max_shift) - CMP_W'(1);
  end

  always_ff @(posedge clk) begin
    target_r  <= target_nxt;
    swl_r     <= swl_nxt;
    win_len_r <= win_len_nxt;
    cmask_r   <= cmask_nxt;
    jmask_r   <= jmask_nxt;
    plan_r    <= plan_nxt;
  end

  always_comb begin
    case (idx)
      REG_TARGET_LOG2:      prdata = PDATA_W'(target_r);
      REG_SIZE_WINDOW_LOG2: prdata = PDATA_W'(swl_r);
      REG_WINDOW_LEN:       prdata = PDATA_W'(win_len_r);
      REG_CHUNK_MASK:       prdata = PDATA_W'(cmask_r);
      REG_JUMP_MASK:        prdata = PDATA_W'(jmask_r);
      default:              prdata = '0;
    endcase
  end

  assign cfg.cut_bits = cmask_r;
  assign cfg.hop_bits = jmask_r;
  assign cfg.plan     = plan_r;

endmodule

/* hdl/jgcb_engine.sv */
// Per-byte phase sequencer, gear fingerprint and chunk bookkeeping.
module jgcb_engine
  import jgcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        commit,
  input  logic [63:0] gear,
  input  logic        last,
  input  cfg_t        cfg,
  input  logic        cfg_wr,
  output res_t        res
);

  logic [OFFSET_W-1:0] byte_offset_r, byte_offset_nxt;
  logic [OFFSET_W-1:0] start_r,       start_nxt;
  logic [OFFSET_W-1:0] len_r,         len_nxt;
  logic [63:0]         fp_r,          fp_nxt;
  logic [1:0]          phase_r,       phase_nxt;
  logic [CD_W-1:0]     cd_r,          cd_nxt;
  logic                reload_r,      reload_nxt;

  logic [63:0]         fp_upd;
  logic                cd_one;
  logic                cut_hash;
  logic                cut_now;
  logic                len_full;
  logic [OFFSET_W-1:0] offset_inc;
  logic [CMP_W-1:0]    len_plus1;
  logic [63:0]         start_wide;

  assign fp_upd     = {fp_r[62:0], 1'b0} + gear;
  assign cd_one     = (cd_r == CD_W'(1));
  assign len_full   = (CMP_W'(len_r) >= cfg.plan.max_m1);
  assign offset_inc = byte_offset_r + OFFSET_W'(1);
  assign len_plus1  = CMP_W'(len_r) + CMP_W'(1);
  assign start_wide = 64'(start_r);

  always_comb begin
    fp_nxt          = fp_r;
    phase_nxt       = phase_r;
    cd_nxt          = cd_r;
    byte_offset_nxt = byte_offset_r;
    start_nxt       = start_r;
    len_nxt         = len_r;
    cut_hash        = 1'b0;
    reload_nxt      = cfg_wr && (len_r == '0);

    case (phase_r)
      PH_SKIP: begin
        if (cd_one) begin
          fp_nxt    = '0;
          phase_nxt = cfg.plan.fill_phase;
          cd_nxt    = cfg.plan.fill_cd;
        end else begin
          cd_nxt = cd_r - CD_W'(1);
        end
      end
      PH_FILL: begin
        fp_nxt = fp_upd;
        cd_nxt = cd_r - CD_W'(1);
        if (cd_one) begin
          phase_nxt = PH_SEARCH;
        end
      end
      PH_SEARCH: begin
        fp_nxt = fp_upd;
        if ((fp_upd & cfg.hop_bits) == '0) begin
          if ((fp_upd & cfg.cut_bits) == '0) begin
            cut_hash = 1'b1;
          end else begin
            phase_nxt = PH_JUMP;
            cd_nxt    = cfg.plan.jump_cd;
          end
        end
      end
      PH_JUMP: begin
        cd_nxt = cd_r - CD_W'(1);
        if (cd_one) begin
          phase_nxt = PH_SEARCH;
        end
      end
      default: ;
    endcase

    cut_now = cut_hash || len_full || last;

    if (cut_now) begin
      byte_offset_nxt = last ? '0 : offset_inc;
      start_nxt       = last ? '0 : offset_inc;
      len_nxt         = '0;
      fp_nxt          = '0;
      phase_nxt       = cfg.plan.first_phase;
      cd_nxt          = cfg.plan.first_cd;
    end else begin
      byte_offset_nxt = offset_inc;
      len_nxt         = len_r + OFFSET_W'(1);
    end

    if (!commit) begin
      byte_offset_nxt = byte_offset_r;
      start_nxt       = start_r;
      len_nxt         = len_r;
      fp_nxt          = fp_r;
      phase_nxt       = phase_r;
      cd_nxt          = cd_r;
      if (reload_r) begin
        fp_nxt    = '0;
        phase_nxt = cfg.plan.first_phase;
        cd_nxt    = cfg.plan.first_cd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      start_r       <= '0;
      len_r         <= '0;
      fp_r          <= '0;
      phase_r       <= PH_SKIP;
      cd_r          <= CD_W'(1);
      reload_r      <= 1'b1;
    end else begin
      byte_offset_r <= byte_offset_nxt;
      start_r       <= start_nxt;
      len_r         <= len_nxt;
      fp_r          <= fp_nxt;
      phase_r       <= phase_nxt;
      cd_r          <= cd_nxt;
      reload_r      <= reload_nxt;
    end
  end

  assign res.cut          = cut_now;
  assign res.chunk_start  = start_wide[START_W-1:0];
  assign res.chunk_length = len_plus1[LEN_W-1:0];

`ifndef ASSERT_OFF
  a_cd_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_SEARCH) |-> (cd_r != '0))
    else $error("counting phase entered with a zero countdown");

  a_cut_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && cut_now) |=> ((len_r == '0) && (fp_r == '0)))
    else $error("chunk state not restarted after a cut");

  a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !cut_now) |=> (byte_offset_r == $past(byte_offset_r) + OFFSET_W'(1)))
    else $error("byte offset did not advance by one");
`endif

endmodule

/* hdl/jump_gear_chunk_boundary.sv */
// Top level of the jump-based gear-hash content-defined chunk boundary finder.
//
// The block takes one byte per transaction on the in_ channel, with in_last_byte
// marking the final byte of a buffer, and emits one out_ transaction with the
// chunk's start offset and length whenever a cut falls. It sustains one byte
// per clock cycle while out_stall does not hold back a pending result. A byte's
// gear value is read from the synchronous gear table ROM at the edge the byte
// is accepted; a single fingerprint shift-add and mask test then updates the
// chunk state and loads the result into the output register.
// Each chunk skips its minimum size less the window unhashed, restarts the
// fingerprint and hashes the window, then searches; when the jump-mask bits
// of the fingerprint are clear it either cuts (chunk-mask bits clear too) or
// skips half the target size. Cuts are also forced at twice the target size
// and at the buffer's last byte, after which offsets restart at zero.
// Registers sit on a 64-bit APB-style port at byte addresses 8*i; write them
// only while no transaction is in flight. No clearing pass follows reset.
module jump_gear_chunk_boundary
  import jgcb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_last_byte,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [START_W-1:0] out_chunk_start,
  output logic [LEN_W-1:0]   out_chunk_length,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_last_r;
  logic               out_valid_r, out_valid_nxt;
  logic [START_W-1:0] out_start_r;
  logic [LEN_W-1:0]   out_len_r;

  logic               adv;
  logic               commit;
  logic               in_acc;
  logic [63:0]        gear;
  cfg_t               cfg;
  logic               cfg_wr;
  res_t               res;

  // The output register frees up when it is empty or its transaction is taken.
  assign adv      = !out_valid_r || !out_stall;
  assign commit   = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  jgcb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // The ROM output register doubles as the byte stage's payload.
  jgcb_gear_rom u_rom (
    .clk     (clk),
    .rd_en   (in_acc),
    .addr    (in_data_byte[GEAR_AW-1:0]),
    .rd_data (gear)
  );

  jgcb_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .gear   (gear),
    .last   (s1_last_r),
    .cfg    (cfg),
    .cfg_wr (cfg_wr),
    .res    (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (commit) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = commit && res.cut;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r <= in_last_byte;
    end
    if (commit && res.cut) begin
      out_start_r <= res.chunk_start;
      out_len_r   <= res.chunk_length;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_start  = out_start_r;
  assign out_chunk_length = out_len_r;

`ifndef ASSERT_OFF
  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(commit))
    else $error("result raised without a committed byte");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r != '0))
    else $error("chunk of zero length reported");

  a_byte_staged: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted byte not held in the lookup stage");
`endif

endmodule
